@@ sv/lsc_pkg.sv @@
// lsc_pkg: shared types, codes and constants for the layered sticker compositor
// no dependencies; imported by lsc_ctrl, lsc_datapath and layered_sticker_compositor

package lsc_pkg;

   localparam int MAX_STICKERS_DEF = 8;
   localparam int CANVAS_DIM_DEF   = 256;

   // command codes
   localparam logic [2:0] CMD_SET_BASE  = 3'd0;
   localparam logic [2:0] CMD_ADD       = 3'd1;
   localparam logic [2:0] CMD_MOVE      = 3'd2;
   localparam logic [2:0] CMD_REMOVE    = 3'd3;
   localparam logic [2:0] CMD_PIX_WRITE = 3'd4;
   localparam logic [2:0] CMD_PIX_READ  = 3'd5;
   localparam logic [2:0] CMD_CLEAR     = 3'd6;

   // result status codes
   localparam logic [1:0] RS_DONE   = 2'd0;
   localparam logic [1:0] RS_REJECT = 2'd1;
   localparam logic [1:0] RS_SKIP   = 2'd2;
   localparam logic [1:0] RS_CLIP   = 2'd3;

   localparam logic [8:0]  SIZE_CAP    = 9'd256;
   localparam logic [8:0]  HUE_WRAP    = 9'd360;
   localparam logic [32:0] WHITE_PIXEL = {8'd255, 8'd255, 8'd0, 9'd0};

   typedef struct packed {
      logic [2:0] command;
      logic [3:0] layer;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [8:0] size_w;
      logic [8:0] size_h;
      logic [7:0] col;
      logic [7:0] row;
      logic [8:0] hue;
      logic [7:0] sat;
      logic [7:0] light;
      logic [7:0] alpha;
   } lsc_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] slot;
      logic [8:0] out_hue;
      logic [7:0] out_sat;
      logic [7:0] out_light;
      logic [7:0] out_alpha;
      logic [8:0] canvas_w;
      logic [8:0] canvas_h;
   } lsc_rsp_type;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [8:0] w;
      logic [8:0] h;
   } lsc_slot_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic add_step;
      logic shift_step;
      logic mem_access;
      logic clear_step;
      logic scan_init;
      logic scan_step;
   } lsc_ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] cmd;
      logic       shift_go;
      logic       dirty;
      logic       add_done;
      logic       shift_last;
      logic       scan_last;
      logic       clear_last;
   } lsc_sts_type;

endpackage

@@ sv/layered_sticker_compositor.sv @@
// layered_sticker_compositor: top level, joins lsc_ctrl and lsc_datapath
// depends on lsc_pkg, lsc_ctrl and lsc_datapath

// An item is taken at a clock edge with start high and busy low, and exactly one
// result follows, shown for a single cycle with rsp_strobe high; the receiver
// cannot hold it, so it must take every result as it comes. busy stays high from
// acceptance through the result cycle. A pixel write or canvas read passes through
// slot lookup, memory access and result; if sticker_limit was written since the
// last table edit, a size scan of every slot is added. Set base, move, add and
// remove end with a size scan that walks the one-port slot table one slot a cycle.
// Clear canvas writes one canvas word a cycle. After reset the block runs the
// same sweep with busy high before it takes the first item; the user must write
// sticker_limit only while no item is in flight, and the block itself does not
// enforce this.

module layered_sticker_compositor
   import lsc_pkg::*;
#(
   parameter int MAX_STICKERS = MAX_STICKERS_DEF,
   parameter int CANVAS_DIM   = CANVAS_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  lsc_req_type req_item,
   output logic        rsp_strobe,
   output lsc_rsp_type rsp_item,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);

   lsc_ctl_type ctl;
   lsc_sts_type sts;

   lsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .sts        (sts),
      .ctl        (ctl)
   );

   lsc_datapath #(
      .MAX_STICKERS (MAX_STICKERS),
      .CANVAS_DIM   (CANVAS_DIM)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_item  (rsp_item)
   );

`ifndef SYNTHESIS
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an item was taken");

   a_slot_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.slot != 4'd0)) |-> (rsp_item.status == RS_DONE))
      else $error("slot reported on a result that is not done");
`endif

endmodule

@@ sv/lsc_ctrl.sv @@
// lsc_ctrl: sequencing state machine for the layered sticker compositor
// depends on lsc_pkg; drives lsc_datapath through lsc_ctl_type commands

module lsc_ctrl
   import lsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_strobe,
   input  lsc_sts_type sts,
   output lsc_ctl_type ctl
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_MEM   = 3'd4;
   localparam logic [2:0] ST_CLEAR = 3'd5;
   localparam logic [2:0] ST_SCAN  = 3'd6;
   localparam logic [2:0] ST_RESP  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       pend_ff, pend_in;
   logic [2:0] finish_state;

   // after the work of an item: refresh the size report if the table changed
   assign finish_state = sts.dirty ? ST_SCAN : ST_RESP;

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
               pend_in  = 1'b1;
            end
         end
         ST_EXEC: begin
            unique case (sts.cmd)
               CMD_SET_BASE, CMD_MOVE:       state_in = ST_SCAN;
               CMD_ADD:                      state_in = ST_ADD;
               CMD_REMOVE:                   state_in = sts.shift_go ? ST_SHIFT : ST_SCAN;
               CMD_PIX_WRITE, CMD_PIX_READ:  state_in = ST_MEM;
               CMD_CLEAR:                    state_in = ST_CLEAR;
               default:                      state_in = finish_state;
            endcase
         end
         ST_ADD: begin
            if (sts.add_done) state_in = ST_SCAN;
         end
         ST_SHIFT: begin
            if (sts.shift_last) state_in = ST_SCAN;
         end
         ST_MEM: begin
            state_in = finish_state;
         end
         ST_CLEAR: begin
            if (sts.clear_last) state_in = pend_ff ? finish_state : ST_IDLE;
         end
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
            pend_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);

   always_comb begin
      ctl            = '0;
      ctl.capture    = (state_ff == ST_IDLE) && start;
      ctl.exec       = (state_ff == ST_EXEC);
      ctl.add_step   = (state_ff == ST_ADD);
      ctl.shift_step = (state_ff == ST_SHIFT);
      ctl.mem_access = (state_ff == ST_MEM);
      ctl.clear_step = (state_ff == ST_CLEAR);
      ctl.scan_step  = (state_ff == ST_SCAN);
      ctl.scan_init  = (state_in == ST_SCAN) && (state_ff != ST_SCAN);
   end

endmodule

@@ sv/lsc_datapath.sv @@
// lsc_datapath: layer table, canvas memory, size report and result registers
// depends on lsc_pkg; sequenced by lsc_ctrl

module lsc_datapath
   import lsc_pkg::*;
#(
   parameter int MAX_STICKERS = MAX_STICKERS_DEF,
   parameter int CANVAS_DIM   = CANVAS_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  lsc_req_type req_item,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata,
   input  lsc_ctl_type ctl,
   output lsc_sts_type sts,
   output lsc_rsp_type rsp_item
);

   localparam int NSLOTS  = MAX_STICKERS + 1;
   localparam int SW      = $clog2(NSLOTS);
   localparam int LCW     = $clog2(NSLOTS + 1);
   localparam int XW      = ((LCW > 4) ? LCW : 4) + 1;
   localparam int LIM_RST = (MAX_STICKERS > 15) ? 15 : MAX_STICKERS;
   localparam int DEPTH   = CANVAS_DIM * CANVAS_DIM;
   localparam int AW      = $clog2(DEPTH);
   localparam int CW      = $clog2(CANVAS_DIM);
   localparam int PW      = ($clog2(CANVAS_DIM + 1) > 9) ? $clog2(CANVAS_DIM + 1) : 9;
   localparam int CAP     = (CANVAS_DIM < 256) ? CANVAS_DIM : 256;

   localparam logic [8:0] CAP9 = 9'(CAP);

   lsc_req_type  req_ff, req_in;
   logic [SW-1:0] idx_ff, idx_in;
   lsc_slot_type tbl_rd_ff;
   lsc_slot_type tbl_mem [NSLOTS];
   logic          tbl_we;
   logic [SW-1:0] tbl_wa;
   lsc_slot_type  tbl_wd;

   logic [NSLOTS-1:0] valid_ff, valid_in;
   logic [LCW-1:0]    lc_ff, lc_in;
   logic [3:0]        limit_ff, limit_in;
   logic              dirty_ff, dirty_in;
   logic [1:0]        status_ff, status_in;
   logic [3:0]        slot_ff, slot_in;
   logic              rdf_ff, rdf_in;
   logic              pix_we_ff, pix_we_in;
   logic [CW-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic [8:0]        cw_ff, cw_in, ch_ff, ch_in;
   logic [AW-1:0]     clr_ff, clr_in;

   logic [32:0] canvas_mem [DEPTH];
   logic [32:0] cv_rd_ff;
   logic        cv_we, cv_re;
   logic [AW-1:0] cv_wa, cv_addr;
   logic [32:0] cv_wd;

   logic [XW-1:0] lx, ix, lim, lcx;
   logic [SW-1:0] idx_dn;
   logic          vld_idx, in_table, ok_slot, pix_ok, shift_go;
   logic          add_over, add_free, add_full, add_place, add_done;
   logic          shift_last, scan_last, clear_last;
   logic [8:0]    src_x, src_y, a_w, a_h, a_wc, a_hc;
   logic          clip_x, clip_y;

   assign lx       = XW'(req_ff.layer);
   assign ix       = XW'(idx_ff);
   assign lim      = XW'(limit_ff);
   assign lcx      = XW'(lc_ff);
   assign idx_dn   = idx_ff - 1'b1;
   assign vld_idx  = (ix < XW'(NSLOTS)) ? valid_ff[idx_ff] : 1'b0;
   assign in_table = (lx < lcx);
   assign ok_slot  = (lx >= XW'(1)) && (lx <= lim) && in_table && vld_idx;
   assign pix_ok   = (lx <= lim) && in_table && vld_idx
                     && ({1'b0, req_ff.col} < tbl_rd_ff.w)
                     && ({1'b0, req_ff.row} < tbl_rd_ff.h);
   assign shift_go = ok_slot && ((lx + XW'(1)) < lcx);

   assign add_over  = (ix > lim);
   assign add_free  = (ix >= lcx) || !vld_idx;
   assign add_full  = (ix == lim);
   assign add_place = !add_over && add_free;
   assign add_done  = add_over || add_free || add_full;

   assign shift_last = ((ix + XW'(1)) >= lcx);
   assign scan_last  = (ix == XW'(NSLOTS - 1));
   assign clear_last = (clr_ff == AW'(DEPTH - 1));

   // canvas coordinates: layer offset for writes, direct for reads
   assign src_x  = (req_ff.command == CMD_PIX_READ) ? {1'b0, req_ff.col}
                   : 9'(tbl_rd_ff.x) + 9'(req_ff.col);
   assign src_y  = (req_ff.command == CMD_PIX_READ) ? {1'b0, req_ff.row}
                   : 9'(tbl_rd_ff.y) + 9'(req_ff.row);
   assign clip_x = (PW'(src_x) >= PW'(CANVAS_DIM));
   assign clip_y = (PW'(src_y) >= PW'(CANVAS_DIM));

   // extent of the slot under scan, saturated
   assign a_w  = 9'(tbl_rd_ff.x) + tbl_rd_ff.w;
   assign a_h  = 9'(tbl_rd_ff.y) + tbl_rd_ff.h;
   assign a_wc = (a_w > CAP9) ? CAP9 : a_w;
   assign a_hc = (a_h > CAP9) ? CAP9 : a_h;

   always_comb begin
      req_in    = req_ff;
      idx_in    = idx_ff;
      tbl_we    = 1'b0;
      tbl_wa    = idx_ff;
      tbl_wd    = tbl_rd_ff;
      valid_in  = valid_ff;
      lc_in     = lc_ff;
      limit_in  = limit_ff;
      dirty_in  = dirty_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      rdf_in    = rdf_ff;
      pix_we_in = pix_we_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cw_in     = cw_ff;
      ch_in     = ch_ff;
      clr_in    = clr_ff;

      if (ctl.capture) begin
         req_in = req_item;
         if (req_item.size_w > SIZE_CAP) req_in.size_w = SIZE_CAP;
         if (req_item.size_h > SIZE_CAP) req_in.size_h = SIZE_CAP;
         if (req_item.hue >= HUE_WRAP) req_in.hue = req_item.hue - HUE_WRAP;
         idx_in = SW'(req_item.layer);
      end

      if (ctl.exec) begin
         status_in = RS_DONE;
         slot_in   = '0;
         rdf_in    = 1'b0;
         pix_we_in = 1'b0;
         cx_in     = clip_x ? CW'(CANVAS_DIM - 1) : CW'(src_x);
         cy_in     = clip_y ? CW'(CANVAS_DIM - 1) : CW'(src_y);
         unique case (req_ff.command)
            CMD_SET_BASE: begin
               tbl_we      = 1'b1;
               tbl_wa      = '0;
               tbl_wd      = '{x: 8'd0, y: 8'd0, w: req_ff.size_w, h: req_ff.size_h};
               valid_in[0] = 1'b1;
            end
            CMD_ADD: begin
               idx_in = SW'(1);
            end
            CMD_MOVE: begin
               if (ok_slot) begin
                  tbl_we = 1'b1;
                  tbl_wd = '{x: req_ff.pos_x, y: req_ff.pos_y,
                             w: tbl_rd_ff.w, h: tbl_rd_ff.h};
               end else begin
                  status_in = RS_REJECT;
               end
            end
            CMD_REMOVE: begin
               if (!ok_slot) begin
                  status_in = RS_REJECT;
               end else if (shift_go) begin
                  idx_in = idx_ff + 1'b1;
               end else begin
                  valid_in[idx_ff] = 1'b0;
                  lc_in            = lc_ff - 1'b1;
               end
            end
            CMD_PIX_WRITE: begin
               if (!pix_ok) begin
                  status_in = RS_REJECT;
               end else if (req_ff.alpha == 8'd0) begin
                  status_in = RS_SKIP;
               end else begin
                  pix_we_in = 1'b1;
                  if (clip_x || clip_y) status_in = RS_CLIP;
               end
            end
            CMD_PIX_READ: begin
               rdf_in = 1'b1;
               if (clip_x || clip_y) status_in = RS_CLIP;
            end
            CMD_CLEAR: begin
               status_in = RS_DONE;
            end
            default: begin
               status_in = RS_REJECT;
            end
         endcase
      end

      // first free sticker slot
      if (ctl.add_step) begin
         if (add_place) begin
            tbl_we           = 1'b1;
            tbl_wd           = '{x: req_ff.pos_x, y: req_ff.pos_y,
                                 w: req_ff.size_w, h: req_ff.size_h};
            valid_in[idx_ff] = 1'b1;
            if (ix >= lcx) lc_in = LCW'(ix + XW'(1));
            status_in        = RS_DONE;
            slot_in          = 4'(idx_ff);
         end else if (add_done) begin
            status_in = RS_REJECT;
            slot_in   = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end

      // move later slots forward by one
      if (ctl.shift_step) begin
         tbl_we           = 1'b1;
         tbl_wa           = idx_dn;
         tbl_wd           = tbl_rd_ff;
         valid_in[idx_dn] = valid_ff[idx_ff];
         if (shift_last) begin
            valid_in[idx_ff] = 1'b0;
            lc_in            = lc_ff - 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end

      if (ctl.scan_step) begin
         if ((ix < lcx) && vld_idx) begin
            if (a_wc > cw_ff) cw_in = a_wc;
            if (a_hc > ch_ff) ch_in = a_hc;
         end
         if (scan_last) dirty_in = 1'b0;
         else           idx_in   = idx_ff + 1'b1;
      end

      if (ctl.scan_init) begin
         idx_in = '0;
         cw_in  = '0;
         ch_in  = '0;
      end

      if (ctl.clear_step) begin
         clr_in = clear_last ? '0 : clr_ff + 1'b1;
      end

      if (csr_we) begin
         if (XW'(csr_wdata) > XW'(MAX_STICKERS)) limit_in = 4'(LIM_RST);
         else                                    limit_in = csr_wdata;
         if (lcx > XW'(csr_wdata) + XW'(1)) lc_in = LCW'(XW'(csr_wdata) + XW'(1));
         for (int i = 0; i < NSLOTS; i++) begin
            if (XW'(i) > XW'(csr_wdata)) valid_in[i] = 1'b0;
         end
         dirty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         lc_ff     <= LCW'(1);
         limit_ff  <= 4'(LIM_RST);
         dirty_ff  <= 1'b0;
         rdf_ff    <= 1'b0;
         pix_we_ff <= 1'b0;
         cw_ff     <= '0;
         ch_ff     <= '0;
         clr_ff    <= '0;
      end else begin
         valid_ff  <= valid_in;
         lc_ff     <= lc_in;
         limit_ff  <= limit_in;
         dirty_ff  <= dirty_in;
         rdf_ff    <= rdf_in;
         pix_we_ff <= pix_we_in;
         cw_ff     <= cw_in;
         ch_ff     <= ch_in;
         clr_ff    <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
   end

   // slot table, read data follows idx_ff, write bypass on same slot
   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
      if (tbl_we && (tbl_wa == idx_in)) tbl_rd_ff <= tbl_wd;
      else                              tbl_rd_ff <= tbl_mem[idx_in];
   end

   // canvas memory: one write port shared by clear sweep and pixel writes
   assign cv_addr = AW'(cy_ff) * AW'(CANVAS_DIM) + AW'(cx_ff);
   assign cv_we   = ctl.clear_step || (ctl.mem_access && pix_we_ff);
   assign cv_wa   = ctl.clear_step ? clr_ff : cv_addr;
   assign cv_wd   = ctl.clear_step ? WHITE_PIXEL
                    : {req_ff.alpha, req_ff.light, req_ff.sat, req_ff.hue};
   assign cv_re   = ctl.mem_access && rdf_ff;

   always_ff @(posedge clock) begin
      if (cv_we) canvas_mem[cv_wa] <= cv_wd;
      if (cv_re) cv_rd_ff <= canvas_mem[cv_addr];
   end

   always_comb begin
      sts            = '0;
      sts.cmd        = req_ff.command;
      sts.shift_go   = shift_go;
      sts.dirty      = dirty_ff;
      sts.add_done   = add_done;
      sts.shift_last = shift_last;
      sts.scan_last  = scan_last;
      sts.clear_last = clear_last;
   end

   always_comb begin
      rsp_item           = '0;
      rsp_item.status    = status_ff;
      rsp_item.slot      = slot_ff;
      rsp_item.canvas_w  = cw_ff;
      rsp_item.canvas_h  = ch_ff;
      if (rdf_ff) begin
         rsp_item.out_hue   = cv_rd_ff[8:0];
         rsp_item.out_sat   = cv_rd_ff[16:9];
         rsp_item.out_light = cv_rd_ff[24:17];
         rsp_item.out_alpha = cv_rd_ff[32:25];
      end
   end

endmodule
